// File: rtl/ssem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssem_pkg;

  localparam int unsigned StoreLines = 32;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned LineBits   = $clog2(StoreLines);
  localparam int unsigned OpBits     = 3;

  // instruction word layout
  localparam int unsigned OpLsb = 13;

  localparam int unsigned InDataBits  = 40;
  localparam int unsigned OutDataBits = 80;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [LineBits-1:0] line_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_EXEC  = 2'd2
  } mode_e;

  typedef enum logic [OpBits-1:0] {
    OP_JMP     = 3'd0,
    OP_JRP     = 3'd1,
    OP_LDN     = 3'd2,
    OP_STO     = 3'd3,
    OP_SUB     = 3'd4,
    OP_SUB_ALT = 3'd5,
    OP_CMP     = 3'd6,
    OP_STP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_OPER
  } state_e;

endpackage

`default_nettype wire

// File: rtl/ssem_processor_step.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: mode, tdata: address, write_data
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: read_data .. halted
//
// Write, read, unused mode and a step while halted retire into the output register
// from the word state once the output register is free, so such beats can follow
// back to back; an executed step also passes the operand state: the instruction
// read is issued with the beat, the operand read in the cycle after it.
// The store is a single synchronous RAM with one read and one write port; the
// next beat is taken in the cycle the current one retires into the output
// register. Reset clears the store through per-line valid bits, with no sweep.
// A full output register that is not drained holds the finishing item.

module ssem_processor_step (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [1:0] mode
  input  wire  [1:0]                   s_axis_tuser_i,
  // [4:0] address, [36:5] write_data, zero fill above
  input  wire  [ssem_pkg::InDataBits-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // [31:0] read_data, [63:32] accumulator, [68:64] counter, [71:69] executed_op,
  // [72] halted, zero fill above
  output logic [ssem_pkg::OutDataBits-1:0] m_axis_tdata_o
);

  import ssem_pkg::*;

  // store
  word_t            mem [StoreLines];
  logic [StoreLines-1:0] valid_q;
  word_t            mem_rd_q;
  logic             vld_rd_q;
  logic             fwd_q;
  word_t            fwd_data_q;

  logic             rd_en;
  line_t            rd_addr;
  logic             wr_en;
  line_t            wr_addr;
  word_t            wr_data;

  // machine state
  word_t            acc_q, acc_d;
  line_t            pc_q, pc_d;
  logic             halt_q, halt_d;

  // item in flight
  state_e           state_q, state_d;
  mode_e            mode_q;
  line_t            addr_q;
  word_t            wdata_q;
  op_e              op_q;
  line_t            sline_q;

  // output register
  logic             out_valid_q;
  word_t            res_read_q, res_acc_q;
  line_t            res_pc_q;
  logic [OpBits-1:0] res_op_q;
  logic             res_halt_q;

  word_t            word;
  word_t            res_read;
  logic [OpBits-1:0] res_op;
  logic             out_free;
  logic             fin;
  logic             accept;

  mode_e            in_mode;
  line_t            in_addr;
  word_t            in_wdata;

  assign in_mode  = mode_e'(s_axis_tuser_i);
  assign in_addr  = s_axis_tdata_i[LineBits-1:0];
  assign in_wdata = s_axis_tdata_i[LineBits +: WordBits];

  // unwritten lines read as zero; a write retiring with the read is forwarded
  assign word = fwd_q ? fwd_data_q : (vld_rd_q ? mem_rd_q : '0);

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    fin      = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = addr_q;
    wr_data  = wdata_q;
    acc_d    = acc_q;
    pc_d     = pc_q;
    halt_d   = halt_q;
    res_read = '0;
    res_op   = '0;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_WORD: begin
        unique case (mode_q)
          MODE_WRITE: begin
            fin   = out_free;
            wr_en = fin;
          end
          MODE_READ: begin
            fin      = out_free;
            res_read = word;
          end
          MODE_EXEC: begin
            if (!halt_q) begin
              // fetch the operand line named by the instruction
              rd_en   = 1'b1;
              rd_addr = word[LineBits-1:0];
              state_d = ST_OPER;
            end else begin
              fin = out_free;
            end
          end
          default: begin
            fin = out_free;
          end
        endcase
      end
      ST_OPER: begin
        fin    = out_free;
        res_op = op_q;
        if (fin) begin
          pc_d = pc_q + line_t'(1);
          unique case (op_q)
            OP_JMP:     pc_d = word[LineBits-1:0] + line_t'(1);
            OP_JRP:     pc_d = pc_q + word[LineBits-1:0] + line_t'(1);
            OP_LDN:     acc_d = '0 - word;
            OP_STO: begin
              wr_en   = 1'b1;
              wr_addr = sline_q;
              wr_data = acc_q;
            end
            OP_SUB,
            OP_SUB_ALT: acc_d = acc_q - word;
            OP_CMP: begin
              if (acc_q[WordBits-1]) pc_d = pc_q + line_t'(2);
            end
            OP_STP:     halt_d = 1'b1;
            default:    halt_d = halt_q;
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    s_axis_tready_o = (state_q == ST_IDLE) || fin;
    accept          = s_axis_tvalid_i && s_axis_tready_o;

    if (fin) state_d = ST_IDLE;
    if (accept) begin
      state_d = ST_WORD;
      rd_en   = 1'b1;
      rd_addr = (in_mode == MODE_READ) ? in_addr : pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_rd_q   <= mem[rd_addr];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (rd_en) begin
        vld_rd_q <= valid_q[rd_addr];
        fwd_q    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_mode;
      addr_q  <= in_addr;
      wdata_q <= in_wdata;
    end
    if (state_q == ST_WORD) begin
      op_q    <= op_e'(word[OpLsb +: OpBits]);
      sline_q <= word[LineBits-1:0];
    end
    if (fin) begin
      res_read_q <= res_read;
      res_acc_q  <= acc_d;
      res_pc_q   <= pc_d;
      res_op_q   <= res_op;
      res_halt_q <= halt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {
    {(OutDataBits - (2 * WordBits + LineBits + OpBits + 1)){1'b0}},
    res_halt_q, res_op_q, res_pc_q, res_acc_q, res_read_q
  };

endmodule

`default_nettype wire

// File: tb/tb_ssem_processor_step.sv
`timescale 1ns / 1ps

module tb_ssem_processor_step;
  import ssem_pkg::*;

  localparam logic [1:0] ModeUnused  = 2'd3;
  localparam int         RandomItems = 1250;
  localparam int         CycleLimit  = 400000;

  typedef struct packed {
    word_t             read_data;
    word_t             accumulator;
    line_t             counter;
    logic [OpBits-1:0] executed_op;
    logic              halted;
  } step_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [1:0]             s_axis_tuser_i = '0;
  logic [InDataBits-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata_o;

  // machine state as seen by the predictor
  word_t        mem_m [StoreLines];
  word_t        acc_m;
  line_t        pc_m;
  logic         halt_m;

  step_result_t expected_q[$];
  int           error_count = 0;
  int           sent_count = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;
  int           stall_left = 0;

  ssem_processor_step u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // instruction word with random filler in the bits the machine ignores
  function automatic word_t make_instr(op_e op, line_t sline);
    word_t w;
    w = $urandom();
    w[LineBits-1:0] = sline;
    w[OpLsb +: OpBits] = op;
    return w;
  endfunction

  function automatic step_result_t advance_machine(logic [1:0] mode, line_t addr, word_t wdata);
    step_result_t res;
    word_t        instr;
    word_t        sval;
    line_t        sline;
    op_e          op;
    res = '0;
    case (mode)
      MODE_WRITE: mem_m[addr] = wdata;
      MODE_READ:  res.read_data = mem_m[addr];
      MODE_EXEC: begin
        if (!halt_m) begin
          instr = mem_m[pc_m];
          sline = instr[LineBits-1:0];
          op    = op_e'(instr[OpLsb +: OpBits]);
          sval  = mem_m[sline];
          case (op)
            OP_JMP:             pc_m = sval[LineBits-1:0];
            OP_JRP:             pc_m = pc_m + sval[LineBits-1:0];
            OP_LDN:             acc_m = word_t'(0) - sval;
            OP_STO:             mem_m[sline] = acc_m;
            OP_SUB, OP_SUB_ALT: acc_m = acc_m - sval;
            OP_CMP:             if (acc_m[WordBits-1]) pc_m = pc_m + line_t'(1);
            default:            halt_m = 1'b1;
          endcase
          pc_m = pc_m + line_t'(1);
          res.executed_op = op;
        end
      end
      default: ;
    endcase
    res.accumulator = acc_m;
    res.counter     = pc_m;
    res.halted      = halt_m;
    return res;
  endfunction

  // valid is left high after the handshake; the next call lowers it only on a gap
  task automatic send_beat(logic [1:0] mode, line_t addr, word_t wdata);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= InDataBits'({wdata, addr});
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(advance_machine(mode, addr, wdata));
    sent_count++;
  endtask

  // replace a stop at the counter unless halting is wanted
  task automatic run_step(bit allow_stop);
    if (!halt_m && !allow_stop && mem_m[pc_m][OpLsb +: OpBits] == OP_STP) begin
      send_beat(MODE_WRITE, pc_m,
                make_instr(op_e'($urandom_range(0, 6)), line_t'($urandom_range(0, 31))));
    end
    send_beat(MODE_EXEC, line_t'($urandom_range(0, 31)), $urandom());
  endtask

  task automatic test_store_access();
    send_beat(MODE_WRITE, 5'd31, 32'hFFFF_FFFF);
    send_beat(MODE_WRITE, 5'd0, 32'h0000_0000);
    send_beat(MODE_READ, 5'd31, 32'h0000_0000);
    send_beat(MODE_READ, 5'd7, 32'hFFFF_FFFF);
    send_beat(ModeUnused, 5'd31, 32'hFFFF_FFFF);
  endtask

  // a short program that walks every opcode but stop, ending in a skip from the last line
  task automatic test_instruction_set();
    send_beat(MODE_WRITE, 5'd0, make_instr(OP_LDN, 5'd20));
    send_beat(MODE_WRITE, 5'd20, 32'd5);
    send_beat(MODE_WRITE, 5'd1, make_instr(OP_SUB, 5'd21));
    send_beat(MODE_WRITE, 5'd21, 32'hFFFF_FFFF);
    send_beat(MODE_WRITE, 5'd2, make_instr(OP_SUB_ALT, 5'd21));
    send_beat(MODE_WRITE, 5'd3, make_instr(OP_STO, 5'd22));
    send_beat(MODE_WRITE, 5'd4, make_instr(OP_CMP, 5'd0));
    send_beat(MODE_WRITE, 5'd6, make_instr(OP_JRP, 5'd23));
    send_beat(MODE_WRITE, 5'd23, 32'd2);
    send_beat(MODE_WRITE, 5'd9, make_instr(OP_JMP, 5'd24));
    send_beat(MODE_WRITE, 5'd24, 32'hFFFF_FFFE);
    send_beat(MODE_WRITE, 5'd31, make_instr(OP_CMP, 5'd31));
    repeat (8) run_step(1'b0);
    send_beat(MODE_READ, 5'd22, 32'd0);
  endtask

  task automatic test_random_programs();
    int         start;
    int         roll;
    int         n;
    logic [1:0] mode;
    line_t      line;
    start = sent_count;
    while (sent_count - start < RandomItems) begin
      steady = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          line = line_t'($urandom_range(0, 31));
          if ($urandom_range(0, 2) != 0) begin
            send_beat(MODE_WRITE, line,
                      make_instr(op_e'($urandom_range(0, 7)), line_t'($urandom_range(0, 31))));
          end else begin
            send_beat(MODE_WRITE, line, $urandom());
          end
        end
        n = $urandom_range(3, 12);
        repeat (n) run_step(1'b0);
      end else if (roll < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          mode = 2'($urandom_range(0, 3));
          if (mode == MODE_EXEC) run_step(1'b0);
          else send_beat(mode, line_t'($urandom_range(0, 31)), $urandom());
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(MODE_READ, line_t'($urandom_range(0, 31)), $urandom());
      end
    end
    steady = 1'b0;
  endtask

  // stop, then show that steps do nothing while store access still works
  task automatic test_halt();
    send_beat(MODE_WRITE, pc_m, make_instr(OP_STP, line_t'($urandom_range(0, 31))));
    run_step(1'b1);
    run_step(1'b1);
    send_beat(MODE_WRITE, 5'd5, 32'hA5A5_5A5A);
    send_beat(MODE_READ, 5'd5, 32'd0);
    send_beat(ModeUnused, 5'd0, 32'd0);
    run_step(1'b1);
  endtask

  function automatic void check_field(string name, logic [WordBits-1:0] want,
                                      logic [WordBits-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("read_data", want.read_data, m_axis_tdata_o[31:0]);
        check_field("accumulator", want.accumulator, m_axis_tdata_o[63:32]);
        check_field("counter", 32'(want.counter), 32'(m_axis_tdata_o[68:64]));
        check_field("executed_op", 32'(want.executed_op), 32'(m_axis_tdata_o[71:69]));
        check_field("halted", 32'(want.halted), 32'(m_axis_tdata_o[72]));
        check_field("fill", 32'd0, 32'(m_axis_tdata_o[OutDataBits-1:73]));
      end
    end
  end

  // output backpressure: short and long stalls, none while steady
  always @(posedge clk_i) begin
    if (steady) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < StoreLines; i++) mem_m[i] = '0;
    acc_m  = '0;
    pc_m   = '0;
    halt_m = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_store_access();
    test_instruction_set();
    test_random_programs();
    test_halt();

    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
